// ----- rtl/core/ipv4dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared constants and types of the dotted-quad address checker.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [9:0] GROUP_MAX = 10'd255;
    localparam logic [1:0] GROUP_LEN = 2'd3;

    localparam logic [4:0] LEN_MIN = 5'd7;
    localparam logic [4:0] LEN_MAX = 5'd15;
    localparam logic [4:0] LEN_SAT = 5'd16;

    localparam logic [2:0] DOTS_NEED = 3'd3;
    localparam logic [2:0] DOT_SAT   = 3'd4;

    // Verdict leaving the scanner toward the result register.
    typedef struct packed {
        logic fire;
        logic ok;
    } result_t;

    // Running counters, exposed for checking.
    typedef struct packed {
        logic [4:0] char_total;
        logic [2:0] dot_total;
    } scan_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/ipv4dq_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_in_stage
// Input register that holds one character until the scanner takes it.
// ----------------------------------------------------------------------------
module ipv4dq_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic       advance,
    input  wire logic [7:0] char_code,
    input  wire logic       is_final,
    output logic            stage_valid,
    output logic [7:0]      stage_char,
    output logic            stage_final
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       final_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg  <= char_code;
            final_reg <= is_final;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_char  = char_reg;
    assign stage_final = final_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ipv4dq_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_scan
// Running state of the address text and the verdict on its last character.
// ----------------------------------------------------------------------------
module ipv4dq_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic [7:0]    stage_char,
    input  wire logic          stage_final,
    output ipv4dq_pkg::result_t      result,
    output ipv4dq_pkg::scan_status_t status
);

    logic [1:0] group_digits_reg, group_digits_next;
    logic [9:0] group_value_reg,  group_value_next;
    logic [2:0] dot_total_reg,    dot_total_next;
    logic [4:0] char_total_reg,   char_total_next;
    logic       prev_dot_reg,     prev_dot_next;
    logic       start_dot_reg,    start_dot_next;
    logic       error_reg,        error_next;

    logic       is_dot;
    logic       is_digit;
    logic [9:0] digit_val;
    logic [9:0] value_acc;
    logic [1:0] digits_inc;
    logic       verdict;

    assign is_dot    = (stage_char == ipv4dq_pkg::CHAR_DOT);
    assign is_digit  = (stage_char >= ipv4dq_pkg::CHAR_ZERO)
                    && (stage_char <= ipv4dq_pkg::CHAR_NINE);
    assign digit_val = {6'd0, stage_char[3:0]};
    // Times ten as two shifts; before the third digit the value is below 100.
    assign value_acc = (group_value_reg << 3) + (group_value_reg << 1) + digit_val;
    assign digits_inc = group_digits_reg + 2'd1;

    always_comb
    begin
        group_digits_next = group_digits_reg;
        group_value_next  = group_value_reg;
        dot_total_next    = dot_total_reg;
        char_total_next   = char_total_reg;
        prev_dot_next     = 1'b0;
        start_dot_next    = start_dot_reg;
        error_next        = error_reg;

        if ((char_total_reg == 5'd0) && is_dot)
        begin
            start_dot_next = 1'b1;
        end
        if (char_total_reg < ipv4dq_pkg::LEN_SAT)
        begin
            char_total_next = char_total_reg + 5'd1;
        end

        if (is_dot)
        begin
            if (prev_dot_reg)
            begin
                error_next = 1'b1;
            end
            group_digits_next = 2'd0;
            group_value_next  = 10'd0;
            if (dot_total_reg < ipv4dq_pkg::DOT_SAT)
            begin
                dot_total_next = dot_total_reg + 3'd1;
            end
            prev_dot_next = 1'b1;
        end
        else if (is_digit)
        begin
            if (group_digits_reg >= ipv4dq_pkg::GROUP_LEN)
            begin
                error_next = 1'b1;
            end
            else
            begin
                group_digits_next = digits_inc;
                group_value_next  = value_acc;
                if ((digits_inc == ipv4dq_pkg::GROUP_LEN)
                    && (value_acc > ipv4dq_pkg::GROUP_MAX))
                begin
                    error_next = 1'b1;
                end
            end
        end
        else
        begin
            error_next = 1'b1;
        end
    end

    assign verdict = !error_next
                  && (dot_total_next == ipv4dq_pkg::DOTS_NEED)
                  && (char_total_next >= ipv4dq_pkg::LEN_MIN)
                  && (char_total_next <= ipv4dq_pkg::LEN_MAX)
                  && !start_dot_next
                  && !is_dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_digits_reg <= 2'd0;
            group_value_reg  <= 10'd0;
            dot_total_reg    <= 3'd0;
            char_total_reg   <= 5'd0;
            prev_dot_reg     <= 1'b0;
            start_dot_reg    <= 1'b0;
            error_reg        <= 1'b0;
        end
        else if (advance)
        begin
            if (stage_final)
            begin
                // The verdict closes the string; start over for the next one.
                group_digits_reg <= 2'd0;
                group_value_reg  <= 10'd0;
                dot_total_reg    <= 3'd0;
                char_total_reg   <= 5'd0;
                prev_dot_reg     <= 1'b0;
                start_dot_reg    <= 1'b0;
                error_reg        <= 1'b0;
            end
            else
            begin
                group_digits_reg <= group_digits_next;
                group_value_reg  <= group_value_next;
                dot_total_reg    <= dot_total_next;
                char_total_reg   <= char_total_next;
                prev_dot_reg     <= prev_dot_next;
                start_dot_reg    <= start_dot_next;
                error_reg        <= error_next;
            end
        end
    end

    assign result.fire       = advance && stage_final;
    assign result.ok         = verdict;
    assign status.char_total = char_total_reg;
    assign status.dot_total  = dot_total_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ipv4dq_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4dq_out_stage
// Result register that holds a verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module ipv4dq_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ipv4dq_pkg::result_t result,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic                     address_ok,
    output logic                     slot_free
);

    logic valid_reg;
    logic valid_next;
    logic ok_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        if (result.fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.fire)
        begin
            ok_reg <= result.ok;
        end
    end

    assign out_valid  = valid_reg;
    assign address_ok = ok_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ipv4_dotted_quad_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Checks an address text, one character per transfer, for dotted-quad form.
//
// The input channel (in_valid, in_stall, char_code, is_final) carries one
// character per transfer; is_final marks the last character of a string.
// The output channel (out_valid, out_stall, address_ok) carries one verdict
// per string, 1 meaning well-formed. Characters other than the last one
// give no output transfer.
// A character lands in an input register and the scanner then updates its
// running counters from it; on the last character the verdict is written to
// the result register and the counters are cleared. One character is taken
// per cycle while the input is not stalled.
// When the receiver stalls, the verdict waits in the result register while
// characters keep flowing; only a second final character stalls the input
// until the register frees up. Reset clears all counters and both valid
// flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            address_ok
);

    logic                     stage_valid;
    logic [7:0]               stage_char;
    logic                     stage_final;
    logic                     slot_free;
    logic                     advance;
    logic                     load;
    ipv4dq_pkg::result_t      result;
    ipv4dq_pkg::scan_status_t status;

    // Non-final characters never need the result register.
    assign advance  = stage_valid && (!stage_final || slot_free);
    assign in_stall = stage_valid && !advance;
    assign load     = in_valid && !in_stall;

    ipv4dq_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .advance     (advance),
        .char_code   (char_code),
        .is_final    (is_final),
        .stage_valid (stage_valid),
        .stage_char  (stage_char),
        .stage_final (stage_final)
    );

    ipv4dq_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_char  (stage_char),
        .stage_final (stage_final),
        .result      (result),
        .status      (status)
    );

    ipv4dq_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .result     (result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .address_ok (address_ok),
        .slot_free  (slot_free)
    );

    a_stall_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid && stage_final && out_valid && out_stall))
        else $error("input stalled without a pending verdict");

    a_verdict_lands: assert property (@(posedge clk) disable iff (!rst_n)
        result.fire |=> out_valid)
        else $error("verdict did not reach the result register");

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        result.fire |=> (status.char_total == 5'd0) && (status.dot_total == 3'd0))
        else $error("counters not cleared after a verdict");

    a_counters_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (status.char_total <= ipv4dq_pkg::LEN_SAT)
        && (status.dot_total <= ipv4dq_pkg::DOT_SAT))
        else $error("counter passed its saturation value");

endmodule
`default_nettype wire

// ----- verif/tb_ipv4_dotted_quad_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_quad_checker
// Feeds address strings to the dotted-quad checker one character per
// transfer. Each string is a short directed case, a well-formed address with
// random groups, a damaged address, noise, or two addresses run together. A
// scanner model follows every accepted character and queues the verdict it
// expects. The monitor compares each verdict that leaves the block with the
// oldest queued one. Both sides idle at random, and once the receiver holds
// off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_quad_checker;

    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [1:0] digits;
        logic [9:0] value;
        logic [2:0] dots;
        logic [4:0] chars;
        logic       prev_dot;
        logic       lead_dot;
        logic       bad;
    } scan_state_t;

    typedef enum int unsigned {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    typedef enum int unsigned {
        MUT_CORRUPT,
        MUT_EXTRA_DOT,
        MUT_TRAIL_DOT,
        MUT_LEAD_DOT,
        MUT_LONG_GROUP,
        MUT_BIG_GROUP,
        MUT_DROP_GROUP,
        MUT_FIFTH_GROUP
    } mutation_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] char_code  = 8'h00;
    logic       is_final   = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       address_ok;

    char_item_t  char_q[$];
    logic [7:0]  text_buf[$];
    logic        verdict_q[$];
    scan_state_t scan = '0;

    idle_mode_t  send_idle = IDLE_NONE;
    idle_mode_t  recv_idle = IDLE_NONE;
    int unsigned queued_items = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned mismatch_count = 0;

    ipv4_dotted_quad_checker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .is_final   (is_final),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .address_ok (address_ok)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Most gaps are short; a few are long enough to drain or fill the block.
    function automatic int unsigned pick_gap(idle_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_LIGHT)
        begin
            if (r < 70) return 0;
            if (r < 93) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Scanner model: advances the running counters by one character and
    // queues the verdict when the character closes the string.
    function automatic void scan_char(logic [7:0] c, logic last);
        logic dot;
        logic digit;
        logic ok;
        dot   = (c == ipv4dq_pkg::CHAR_DOT);
        digit = (c >= ipv4dq_pkg::CHAR_ZERO) && (c <= ipv4dq_pkg::CHAR_NINE);
        if (scan.chars == 5'd0 && dot)
            scan.lead_dot = 1'b1;
        if (scan.chars < ipv4dq_pkg::LEN_SAT)
            scan.chars = scan.chars + 5'd1;
        if (dot)
        begin
            if (scan.prev_dot)
                scan.bad = 1'b1;
            scan.digits = 2'd0;
            scan.value  = 10'd0;
            if (scan.dots < ipv4dq_pkg::DOT_SAT)
                scan.dots = scan.dots + 3'd1;
            scan.prev_dot = 1'b1;
        end
        else if (digit)
        begin
            if (scan.digits >= ipv4dq_pkg::GROUP_LEN)
                scan.bad = 1'b1;
            else
            begin
                scan.digits = scan.digits + 2'd1;
                scan.value  = 10'(scan.value * 10 + (c - ipv4dq_pkg::CHAR_ZERO));
                if (scan.digits == ipv4dq_pkg::GROUP_LEN
                    && scan.value > ipv4dq_pkg::GROUP_MAX)
                    scan.bad = 1'b1;
            end
            scan.prev_dot = 1'b0;
        end
        else
        begin
            scan.bad      = 1'b1;
            scan.prev_dot = 1'b0;
        end
        if (last)
        begin
            ok = !scan.bad && scan.dots == ipv4dq_pkg::DOTS_NEED
                 && scan.chars >= ipv4dq_pkg::LEN_MIN
                 && scan.chars <= ipv4dq_pkg::LEN_MAX && !scan.lead_dot && !dot;
            verdict_q.insert(verdict_q.size(), ok);
            scan = '0;
        end
    endfunction

    // Appends one character to the string under construction.
    function automatic void add_char(logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void put_number(int unsigned v, int unsigned width);
        int unsigned div;
        div = 1;
        for (int unsigned i = 1; i < width; i++)
            div = div * 10;
        for (int unsigned i = 0; i < width; i++)
        begin
            add_char(ipv4dq_pkg::CHAR_ZERO + 8'((v / div) % 10));
            div = div / 10;
        end
    endfunction

    // Writes a group in its shortest form, or now and then with leading zeros.
    function automatic void put_group(int unsigned v);
        int unsigned w;
        w = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
        if ($urandom_range(0, 4) == 0)
            w = $urandom_range(w, 3);
        put_number(v, w);
    endfunction

    function automatic int unsigned pick_octet();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(10, 99);
            2: return $urandom_range(100, 255);
            default: return $urandom_range(250, 255);
        endcase
    endfunction

    // A group index of 4 or more leaves every group in range.
    function automatic void build_address(int unsigned big_group);
        for (int unsigned g = 0; g < 4; g++)
        begin
            if (g != 0)
                add_char(ipv4dq_pkg::CHAR_DOT);
            if (g == big_group)
                put_group($urandom_range(256, 999));
            else
                put_group(pick_octet());
        end
    endfunction

    function automatic void damage_text();
        mutation_t   kind;
        int unsigned pos;
        kind = mutation_t'($urandom_range(0, 7));
        pos  = $urandom_range(0, text_buf.size() - 1);
        case (kind)
            MUT_CORRUPT:     text_buf[pos] = 8'($urandom_range(0, 255));
            MUT_EXTRA_DOT:   text_buf.insert(pos, ipv4dq_pkg::CHAR_DOT);
            MUT_TRAIL_DOT:   add_char(ipv4dq_pkg::CHAR_DOT);
            MUT_LEAD_DOT:    text_buf.push_front(ipv4dq_pkg::CHAR_DOT);
            MUT_LONG_GROUP:  add_char(ipv4dq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            MUT_BIG_GROUP:
            begin
                text_buf.delete();
                build_address($urandom_range(0, 3));
            end
            MUT_DROP_GROUP:
            begin
                while (text_buf.size() > 1 && text_buf[$] != ipv4dq_pkg::CHAR_DOT)
                    void'(text_buf.pop_back());
                if (text_buf.size() > 1)
                    void'(text_buf.pop_back());
            end
            default:
            begin
                add_char(ipv4dq_pkg::CHAR_DOT);
                put_group(pick_octet());
            end
        endcase
    endfunction

    // Moves the string under construction to the send queue, marking its end.
    function automatic void commit_text();
        if (text_buf.size() == 0)
            add_char(ipv4dq_pkg::CHAR_ZERO);
        foreach (text_buf[i])
            char_q.insert(char_q.size(),
                          '{code: text_buf[i], last: (i == text_buf.size() - 1)});
        queued_items += text_buf.size();
        text_buf.delete();
    endfunction

    task automatic queue_random(int unsigned n_items);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        start = queued_items;
        while (queued_items - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                build_address(4);
            else if (r < 80)
            begin
                build_address(4);
                damage_text();
            end
            else if (r < 92)
            begin
                len = $urandom_range(1, 20);
                repeat (len)
                begin
                    case ($urandom_range(0, 2))
                        0: add_char(ipv4dq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                        1: add_char(ipv4dq_pkg::CHAR_DOT);
                        default: add_char(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                // Two addresses run together overflow the dot count and, unless every group is one digit, the length.
                build_address(4);
                add_char(ipv4dq_pkg::CHAR_DOT);
                build_address(4);
            end
            commit_text();
        end
    endtask

    // Input driver: one character per transfer, with random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        char_item_t item;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'h00;
            is_final  <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                scan_char(char_code, is_final);
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (char_q.size() != 0)
                begin
                    item = char_q.pop_front();
                    in_valid  <= 1'b1;
                    char_code <= item.code;
                    is_final  <= item.last;
                    send_gap  <= pick_gap(send_idle);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Verdict monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        logic        expected_ok;
        int unsigned wait_n;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("address_ok: unexpected transfer, actual %0d", address_ok);
                    mismatch_count++;
                end
                else
                begin
                    expected_ok = verdict_q.pop_front();
                    if (address_ok !== expected_ok)
                    begin
                        $error("address_ok mismatch: expected %0d, actual %0d",
                               expected_ok, address_ok);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0)
                wait_n = stall_left - 1;
            else
                wait_n = pick_gap(recv_idle);
            stall_left <= wait_n;
            out_stall  <= (wait_n != 0) || (hold_left != 0);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Byte extremes, a lone dot, the shortest and longest good addresses,
        // and one string with an oversized group, a four-digit group, two dots
        // in a row and an illegal byte.
        add_char(8'h00);
        commit_text();
        add_char(ipv4dq_pkg::CHAR_DOT);
        commit_text();
        for (int unsigned g = 0; g < 4; g++)
        begin
            if (g != 0)
                add_char(ipv4dq_pkg::CHAR_DOT);
            put_number(0, 1);
        end
        commit_text();
        for (int unsigned g = 0; g < 4; g++)
        begin
            if (g != 0)
                add_char(ipv4dq_pkg::CHAR_DOT);
            put_number(255, 3);
        end
        commit_text();
        put_number(256, 3);
        add_char(ipv4dq_pkg::CHAR_DOT);
        put_number(7777, 4);
        add_char(ipv4dq_pkg::CHAR_DOT);
        add_char(ipv4dq_pkg::CHAR_DOT);
        add_char(8'hFF);
        commit_text();

        queue_random(300);
        while (char_q.size() != 0)
            @(posedge clk);

        send_idle <= IDLE_LIGHT;
        recv_idle <= IDLE_LIGHT;
        queue_random(500);
        while (char_q.size() != 0)
            @(posedge clk);

        // The receiver holds off while characters keep coming, so a second
        // verdict has nowhere to go and the input stalls.
        send_idle     <= IDLE_NONE;
        hold_requests <= hold_requests + 1;
        queue_random(200);
        while (char_q.size() != 0)
            @(posedge clk);

        send_idle <= IDLE_LIGHT;
        recv_idle <= IDLE_HEAVY;
        queue_random(200);

        while (char_q.size() != 0 || in_valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS ipv4_dotted_quad_checker");
        else
            $display("FAIL ipv4_dotted_quad_checker");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL ipv4_dotted_quad_checker");
        $finish;
    end

endmodule
